### hdl/dfs_pkg.sv
package dfs_pkg;

	localparam int MOTOR_COUNT_DEF = 16;
	localparam int ID_W            = 4;
	localparam int STATUS_W        = 16;
	localparam int COUNT_W         = 32;
	localparam int CTRL_W          = 8;
	localparam int MASK_W          = 16;
	localparam int REG_IDX_W       = 8;
	localparam int REG_DATA_W      = 16;

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_DRIVE_INITIALIZED  = 8'd0;
	localparam logic [REG_IDX_W-1:0] REG_BRAKE_ENGAGED      = 8'd1;
	localparam logic [REG_IDX_W-1:0] REG_SEQUENCE_SKIP_MASK = 8'd2;
	localparam logic [REG_IDX_W-1:0] REG_REPORT_MASK        = 8'd3;

	// CiA 402 status word decoding.
	localparam logic [STATUS_W-1:0] STATUS_MASK        = 16'h004F;
	localparam logic [STATUS_W-1:0] ST_NOT_READY       = 16'h0000;
	localparam logic [STATUS_W-1:0] ST_SW_ON_DISABLED  = 16'h0040;
	localparam logic [STATUS_W-1:0] ST_READY           = 16'h0001;
	localparam logic [STATUS_W-1:0] ST_SWITCHED_ON     = 16'h0003;
	localparam logic [STATUS_W-1:0] ST_OP_ENABLED      = 16'h0007;
	localparam logic [STATUS_W-1:0] ST_FAULT           = 16'h0008;

	// CiA 402 control words.
	localparam logic [CTRL_W-1:0] CW_NONE        = 8'h00;
	localparam logic [CTRL_W-1:0] CW_SHUTDOWN    = 8'h06;
	localparam logic [CTRL_W-1:0] CW_SWITCH_ON   = 8'h07;
	localparam logic [CTRL_W-1:0] CW_ENABLE_OP   = 8'h0F;
	localparam logic [CTRL_W-1:0] CW_FAULT_RESET = 8'h80;

	// Encoder delta limits.
	localparam logic [COUNT_W-1:0] ROLL_SPAN        = 32'd16777216;
	localparam logic [COUNT_W-1:0] ROLL_WINDOW      = 32'd5000;
	localparam logic [COUNT_W-1:0] ROLL_LOW         = ROLL_SPAN - ROLL_WINDOW;
	localparam logic [COUNT_W-1:0] ROLL_HIGH        = ROLL_SPAN + ROLL_WINDOW;
	localparam logic [COUNT_W-1:0] ZERO_RESET_LIMIT = 32'd10000;
	localparam logic [COUNT_W-1:0] JUMP_LIMIT       = 32'd1000000;

endpackage

### hdl/dfs_channels.sv
interface dfs_feedback_if;
	logic                                 valid;
	logic                                 ready;
	logic [dfs_pkg::ID_W-1:0]             drive_id;
	logic [dfs_pkg::STATUS_W-1:0]         status_word;
	logic signed [dfs_pkg::COUNT_W-1:0]   encoder_count;

	modport source (output valid, drive_id, status_word, encoder_count, input ready);
	modport sink (input valid, drive_id, status_word, encoder_count, output ready);
endinterface

interface dfs_result_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 command_valid;
	logic [dfs_pkg::CTRL_W-1:0]           control_word;
	logic                                 report_valid;
	logic signed [dfs_pkg::COUNT_W-1:0]   position_delta;
	logic                                 rollover_fixed;
	logic                                 large_jump;
	logic                                 brake_feedback;

	modport source (output valid, command_valid, control_word, report_valid, position_delta,
		rollover_fixed, large_jump, brake_feedback, input ready);
	modport sink (input valid, command_valid, control_word, report_valid, position_delta,
		rollover_fixed, large_jump, brake_feedback, output ready);
endinterface

interface dfs_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [dfs_pkg::REG_IDX_W-1:0]        reg_index;
	logic [dfs_pkg::REG_DATA_W-1:0]       wr_data;

	modport source (output valid, reg_index, wr_data, input ready);
	modport sink (input valid, reg_index, wr_data, output ready);
endinterface

### hdl/drive_feedback_supervisor_unit.sv
// Channel    Role    Request carries
// feedback   sink    drive_id, status_word, encoder_count
// result     source  command, control word, report flags, position delta and flags
// cfg        sink    reg_index, wr_data (always ready)
//
// One request is taken per cycle while feedback ready is high; it is registered in s1, then
// s2, then the output register, where its result stays valid until result ready takes it.
// Stages: previous-count memory read (s1), raw delta (s2), rollover and jump check (output).
// The memory is read and written at the same edge and returns the old entry, so the same id
// on consecutive requests needs no forwarding.
// arst_n clears the stage valids, the configuration and the per-entry valid bits;
// an entry never written reads as zero. A stalled output fills the pipeline before feedback
// ready drops.
module drive_feedback_supervisor_unit #(
	parameter int MOTOR_COUNT = dfs_pkg::MOTOR_COUNT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	dfs_feedback_if.sink feedback,
	dfs_result_if.source result,
	dfs_cfg_if.sink      cfg
);

	localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

	// Configuration registers.
	logic                          drive_init_q;
	logic                          brake_q;
	logic [dfs_pkg::MASK_W-1:0]    skip_mask_q;
	logic [dfs_pkg::MASK_W-1:0]    report_mask_q;

	// Previous-count store.
	logic [dfs_pkg::COUNT_W-1:0]   mem [MOTOR_COUNT];
	logic [MOTOR_COUNT-1:0]        ent_vld_q;

	logic                          acc;
	logic                          in_tab;
	logic [IDX_W-1:0]              idx;

	// Stage 1.
	logic                          v_s1;
	logic [dfs_pkg::COUNT_W-1:0]   rd_s1;
	logic                          rdv_s1;
	logic                          intab_s1;
	logic [dfs_pkg::COUNT_W-1:0]   count_s1;
	logic [dfs_pkg::STATUS_W-1:0]  masked_s1;
	logic                          allow_s1;
	logic                          rep_s1;

	// Stage 2.
	logic                          v_s2;
	logic [dfs_pkg::COUNT_W-1:0]   delta_s2;
	logic                          cmd_s2;
	logic [dfs_pkg::CTRL_W-1:0]    cw_s2;
	logic                          rep_s2;
	logic                          brake_fb_s2;

	logic                          out_v_q;
	logic                          adv_out;
	logic                          adv_s2;
	logic                          adv_s1;

	logic [dfs_pkg::COUNT_W-1:0]   prev;
	logic [dfs_pkg::COUNT_W-1:0]   prev_mag;
	logic                          zero_rst;
	logic [dfs_pkg::COUNT_W-1:0]   delta_raw;
	logic                          cmd;
	logic [dfs_pkg::CTRL_W-1:0]    cw;

	logic [dfs_pkg::COUNT_W-1:0]   mag;
	logic                          rolled;
	logic [dfs_pkg::COUNT_W-1:0]   delta_fix;
	logic                          jump;

	assign adv_out        = !out_v_q || result.ready;
	assign adv_s2         = !v_s2 || adv_out;
	assign adv_s1         = !v_s1 || adv_s2;
	assign feedback.ready = adv_s1;
	assign acc            = feedback.valid && feedback.ready;
	assign cfg.ready      = 1'b1;

	assign in_tab = 32'(feedback.drive_id) < MOTOR_COUNT;
	assign idx    = IDX_W'(feedback.drive_id);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_init_q  <= 1'b0;
			brake_q       <= 1'b0;
			skip_mask_q   <= '0;
			report_mask_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				dfs_pkg::REG_DRIVE_INITIALIZED:  drive_init_q  <= cfg.wr_data[0];
				dfs_pkg::REG_BRAKE_ENGAGED:      brake_q       <= cfg.wr_data[0];
				dfs_pkg::REG_SEQUENCE_SKIP_MASK: skip_mask_q   <= cfg.wr_data;
				dfs_pkg::REG_REPORT_MASK:        report_mask_q <= cfg.wr_data;
				default: ;
			endcase
		end
	end

	// Read-first memory: the read at an edge sees the entry before that edge's write.
	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1 <= mem[idx];
			if (in_tab) begin
				mem[idx] <= feedback.encoder_count;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (acc && in_tab) begin
				ent_vld_q[idx] <= 1'b1;
			end
			if (adv_s1) begin
				v_s1 <= acc;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
			if (adv_out) begin
				out_v_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rdv_s1    <= in_tab && ent_vld_q[idx];
			intab_s1  <= in_tab;
			count_s1  <= feedback.encoder_count;
			masked_s1 <= feedback.status_word & dfs_pkg::STATUS_MASK;
			allow_s1  <= drive_init_q && !brake_q && !skip_mask_q[feedback.drive_id];
			rep_s1    <= report_mask_q[feedback.drive_id];
		end
	end

	// Stage 1: previous count, zero-reset rule and raw delta.
	always_comb begin
		prev      = (intab_s1 && rdv_s1) ? rd_s1 : '0;
		prev_mag  = prev[dfs_pkg::COUNT_W-1] ? (~prev + 32'd1) : prev;
		zero_rst  = (count_s1 == '0) && (prev_mag > dfs_pkg::ZERO_RESET_LIMIT);
		delta_raw = zero_rst ? '0 : (count_s1 - prev);

		cmd = 1'b0;
		cw  = dfs_pkg::CW_NONE;
		if (allow_s1) begin
			case (masked_s1) inside
				dfs_pkg::ST_NOT_READY, dfs_pkg::ST_SW_ON_DISABLED: begin
					cmd = 1'b1;
					cw  = dfs_pkg::CW_SHUTDOWN;
				end
				dfs_pkg::ST_READY: begin
					cmd = 1'b1;
					cw  = dfs_pkg::CW_SWITCH_ON;
				end
				dfs_pkg::ST_SWITCHED_ON: begin
					cmd = 1'b1;
					cw  = dfs_pkg::CW_ENABLE_OP;
				end
				dfs_pkg::ST_FAULT: begin
					cmd = 1'b1;
					cw  = dfs_pkg::CW_FAULT_RESET;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			delta_s2    <= delta_raw;
			cmd_s2      <= cmd;
			cw_s2       <= cw;
			rep_s2      <= rep_s1;
			brake_fb_s2 <= rep_s1 && (masked_s1 != dfs_pkg::ST_OP_ENABLED);
		end
	end

	// Stage 2: a corrected delta is always below the jump limit, so the jump test can use the
	// raw magnitude when no rollover correction applies.
	always_comb begin
		mag    = delta_s2[dfs_pkg::COUNT_W-1] ? (~delta_s2 + 32'd1) : delta_s2;
		rolled = (mag > dfs_pkg::ROLL_LOW) && (mag < dfs_pkg::ROLL_HIGH);
		if (!rolled) begin
			delta_fix = delta_s2;
		end else if (delta_s2[dfs_pkg::COUNT_W-1]) begin
			delta_fix = delta_s2 + dfs_pkg::ROLL_SPAN;
		end else begin
			delta_fix = delta_s2 - dfs_pkg::ROLL_SPAN;
		end
		jump = !rolled && (mag > dfs_pkg::JUMP_LIMIT);
	end

	always_ff @(posedge clk) begin
		if (adv_out && v_s2) begin
			result.command_valid  <= cmd_s2;
			result.control_word   <= cw_s2;
			result.report_valid   <= rep_s2;
			result.position_delta <= delta_fix;
			result.rollover_fixed <= rolled;
			result.large_jump     <= jump;
			result.brake_feedback <= brake_fb_s2;
		end
	end

	assign result.valid = out_v_q;

`ifndef ASSERT_OFF
	a_accept_enters_s1: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> v_s1)
		else $error("accepted request did not reach stage 1");

	a_entry_marked: assert property (@(posedge clk) disable iff (!arst_n)
		acc && in_tab |=> ent_vld_q[$past(idx)])
		else $error("written entry not marked valid");

	a_roll_no_jump: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> !(result.rollover_fixed && result.large_jump))
		else $error("corrected delta flagged as large jump");

	a_no_cmd_zero_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !result.command_valid |-> result.control_word == dfs_pkg::CW_NONE)
		else $error("control word without command");

	a_brake_needs_report: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && result.brake_feedback |-> result.report_valid)
		else $error("brake feedback on unreported id");
`endif

endmodule
